// ----- hw/rtl/terminal_mouse_report_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// Terminal mouse report encoder - assertion macros
// Shared concurrent assertion wrappers; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_MOUSE_REPORT_ENCODER_DEFINES_SVH
`define TERMINAL_MOUSE_REPORT_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset
`define TMRE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never occurs outside reset
`define TMRE_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TMRE_ASSERT(lbl, clk, rst_n, prop, msg)
`define TMRE_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/tmre_pkg.sv -----
// ----------------------------------------------------------------------------
// Terminal mouse report encoder - package
// Types, byte codes and helper functions shared by the encoder modules.
// ----------------------------------------------------------------------------
package tmre_pkg;

	// Coordinate handling
	localparam int COORD_BITS_DEF = 12;
	localparam int COORD_MAX      = 12;
	localparam int QUEUE_DEPTH    = 2;

	// Decimal step: q = (v * RECIP) >> RECIP_SHIFT is exact for v below 16384
	localparam logic [12:0] RECIP       = 13'd6554;
	localparam int          RECIP_SHIFT = 16;

	// Event kinds
	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_DRAG    = 2'd2,
		EV_MOVE    = 2'd3
	} ev_kind_t;

	// Tracking modes that filter events; other codes pass all but wheel releases
	localparam logic [1:0] MODE_PRESS_ONLY = 2'd0;
	localparam logic [1:0] MODE_BUTTON     = 2'd1;
	localparam logic [1:0] MODE_RESET      = 2'd2;

	// Configuration register indexes
	typedef enum logic {
		REG_TRACKING_MODE = 1'b0,
		REG_SGR_FORMAT    = 1'b1
	} cfg_reg_t;
	localparam int CFG_DATA_W = 2;

	// Button codes
	localparam logic [6:0] BTN_WHEEL_UP   = 7'd64;
	localparam logic [6:0] BTN_WHEEL_DOWN = 7'd65;
	localparam logic [6:0] CODE_RELEASE   = 7'd3;
	localparam logic [6:0] CODE_MOTION    = 7'd32;

	// Report bytes
	localparam logic [7:0] CH_ESC        = 8'h1B;
	localparam logic [7:0] CH_LBRACKET   = 8'h5B;
	localparam logic [7:0] CH_LESS       = 8'h3C;
	localparam logic [7:0] CH_UPPER_M    = 8'h4D;
	localparam logic [7:0] CH_LOWER_M    = 8'h6D;
	localparam logic [7:0] CH_SEMI       = 8'h3B;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] LEGACY_OFFSET = 8'd32;

	// One classified event between front and back
	typedef struct packed {
		logic             sgr;
		logic             rel;
		logic [1:0]       len_c;   // digit count minus one
		logic [1:0]       len_x;
		logic [1:0]       len_y;
		logic [3:0][3:0]  dig_c;   // decimal digits, ones first
		logic [3:0][3:0]  dig_x;
		logic [3:0][3:0]  dig_y;
		logic [7:0]       b_code;  // legacy bytes, offset included
		logic [7:0]       b_x;
		logic [7:0]       b_y;
	} tmre_desc_t;

	// Serializer states
	typedef enum logic [3:0] {
		S_ESC,
		S_LBRK,
		S_INTRO,
		S_LCODE,
		S_LX,
		S_LY,
		S_CODE,
		S_SEMI1,
		S_XNUM,
		S_SEMI2,
		S_YNUM,
		S_TERM
	} back_state_t;

	// Quotient of a value by ten
	function automatic logic [11:0] div10(input logic [11:0] v);
		logic [24:0] p;
		p = 25'(v) * 25'(RECIP);
		return 12'(p[24:RECIP_SHIFT]);
	endfunction

	// Number of decimal digits minus one
	function automatic logic [1:0] dec_len(input logic [11:0] v);
		logic [1:0] n;
		if (v >= 12'd1000) n = 2'd3;
		else if (v >= 12'd100) n = 2'd2;
		else if (v >= 12'd10) n = 2'd1;
		else n = 2'd0;
		return n;
	endfunction

endpackage

// ----- hw/rtl/tmre_front.sv -----
// ----------------------------------------------------------------------------
// Terminal mouse report encoder - front end
// Accepts events, filters them by tracking mode, builds the button code and
// extracts SGR decimal digits one per cycle before handing a descriptor on.
// ----------------------------------------------------------------------------
`include "terminal_mouse_report_encoder_defines.svh"

module tmre_front import tmre_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [6:0]  button_code,
	input  logic [1:0]  event_kind,
	input  logic        shift_held,
	input  logic        option_held,
	input  logic        control_held,
	input  logic [11:0] column,
	input  logic [11:0] row,
	input  logic [1:0]  tracking_mode,
	input  logic        sgr_format,
	output logic        q_push,
	output tmre_desc_t  q_desc,
	input  logic        q_full
);

	localparam int CW = (COORD_BITS < COORD_MAX) ? COORD_BITS : COORD_MAX;

	logic          busy_q, done_q;
	logic [1:0]    cnt_q;
	logic [6:0]    cv_q;
	logic [CW-1:0] xv_q, yv_q;
	logic [3:0][3:0] dc_q, dx_q, dy_q;
	logic          sgr_q, rel_q;
	logic [1:0]    lc_q, lx_q, ly_q;

	logic          accept, step, pass, wheel;
	logic [6:0]    mods, sgr_code, code_in;
	logic [CW-1:0] x_in, y_in;
	logic [11:0]   cq, xq, yq, cr, xr, yr;

	// Handshake
	assign q_push = busy_q && done_q && !q_full;
	assign full   = busy_q && !q_push;
	assign accept = push && !full;
	assign step   = busy_q && !done_q;

	// Classify the incoming event
	always_comb begin
		x_in  = column[CW-1:0];
		y_in  = row[CW-1:0];
		wheel = (button_code == BTN_WHEEL_UP) || (button_code == BTN_WHEEL_DOWN);
		mods  = {2'b00, control_held, option_held, shift_held, 2'b00};
		pass  = 1'b1;
		if (tracking_mode == MODE_PRESS_ONLY && ev_kind_t'(event_kind) != EV_PRESS)
			pass = 1'b0;
		if (tracking_mode == MODE_BUTTON && ev_kind_t'(event_kind) == EV_MOVE)
			pass = 1'b0;
		if (wheel && ev_kind_t'(event_kind) == EV_RELEASE)
			pass = 1'b0;
		unique case (ev_kind_t'(event_kind))
			EV_PRESS:   sgr_code = button_code | mods;
			EV_RELEASE: sgr_code = CODE_RELEASE | mods;
			EV_DRAG:    sgr_code = button_code | CODE_MOTION | mods;
			EV_MOVE:    sgr_code = CODE_RELEASE | CODE_MOTION | mods;
			default:    sgr_code = button_code | mods;
		endcase
		code_in = (!sgr_format && wheel) ? (button_code | mods) : sgr_code;
	end

	// One decimal step on each lane
	always_comb begin
		cq = div10(12'(cv_q));
		xq = div10(12'(xv_q));
		yq = div10(12'(yv_q));
		cr = 12'(cv_q) - ((cq << 3) + (cq << 1));
		xr = 12'(xv_q) - ((xq << 3) + (xq << 1));
		yr = 12'(yv_q) - ((yq << 3) + (yq << 1));
	end

	// Control: load on accept, count digit steps, release on hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else if (accept) begin
			busy_q <= pass;
			done_q <= !sgr_format;
			cnt_q  <= 2'd0;
		end else if (q_push) begin
			busy_q <= 1'b0;
		end else if (step) begin
			cnt_q  <= cnt_q + 2'd1;
			done_q <= (cnt_q == 2'd3);
		end
	end

	// Payload: capture the event, then shift out digits
	always_ff @(posedge clk) begin
		if (accept) begin
			cv_q  <= code_in;
			xv_q  <= x_in;
			yv_q  <= y_in;
			sgr_q <= sgr_format;
			rel_q <= (ev_kind_t'(event_kind) == EV_RELEASE);
			lc_q  <= dec_len(12'(code_in));
			lx_q  <= dec_len(12'(x_in));
			ly_q  <= dec_len(12'(y_in));
		end else if (step) begin
			cv_q        <= 7'(cq);
			xv_q        <= CW'(xq);
			yv_q        <= CW'(yq);
			dc_q[cnt_q] <= cr[3:0];
			dx_q[cnt_q] <= xr[3:0];
			dy_q[cnt_q] <= yr[3:0];
		end
	end

	// Build the descriptor
	always_comb begin
		q_desc.sgr    = sgr_q;
		q_desc.rel    = rel_q;
		q_desc.len_c  = lc_q;
		q_desc.len_x  = lx_q;
		q_desc.len_y  = ly_q;
		q_desc.dig_c  = dc_q;
		q_desc.dig_x  = dx_q;
		q_desc.dig_y  = dy_q;
		q_desc.b_code = 8'(cv_q) + LEGACY_OFFSET;
		q_desc.b_x    = xv_q[7:0] + LEGACY_OFFSET;
		q_desc.b_y    = yv_q[7:0] + LEGACY_OFFSET;
	end

	`TMRE_ASSERT(a_conv_holds, clk, arst_n, step |=> busy_q, "conversion dropped an event")
	`TMRE_ASSERT(a_conv_blocks, clk, arst_n, step |-> full, "input open during conversion")

endmodule

// ----- hw/rtl/tmre_queue.sv -----
// ----------------------------------------------------------------------------
// Terminal mouse report encoder - descriptor queue
// Short register queue that decouples classification from serialization.
// ----------------------------------------------------------------------------
`include "terminal_mouse_report_encoder_defines.svh"

module tmre_queue import tmre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tmre_desc_t wdata,
	output logic       full,
	input  logic       pop,
	output tmre_desc_t rdata,
	output logic       empty
);

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	tmre_desc_t    mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CNTW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNTW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNTW'(1);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

	`TMRE_NEVER(a_q_over, clk, arst_n, count_q > CNTW'(DEPTH), "queue count overflow")
	`TMRE_NEVER(a_q_push_full, clk, arst_n, push && full, "push into full queue")
	`TMRE_NEVER(a_q_pop_empty, clk, arst_n, pop && empty, "pop from empty queue")

endmodule

// ----- hw/rtl/tmre_back.sv -----
// ----------------------------------------------------------------------------
// Terminal mouse report encoder - back end
// Walks the head descriptor and emits one report byte per cycle, while the
// consumer keeps popping, into an output register, marking the final byte.
// ----------------------------------------------------------------------------
`include "terminal_mouse_report_encoder_defines.svh"

module tmre_back import tmre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  tmre_desc_t q_desc,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       last_byte
);

	back_state_t state_q, state_n;
	logic [1:0]  dig_q, dig_n;
	logic        out_valid_q;
	logic [7:0]  byte_q, byte_c;
	logic        last_q, last_c;
	logic        emit;
	logic [3:0]  digit;

	assign empty     = !out_valid_q;
	assign out_byte  = byte_q;
	assign last_byte = last_q;
	assign emit      = (!out_valid_q || pop) && !q_empty;
	assign q_pop     = emit && last_c;

	// Next byte and sequencing
	always_comb begin
		state_n = state_q;
		dig_n   = dig_q;
		byte_c  = CH_ESC;
		last_c  = 1'b0;
		digit   = 4'd0;
		unique case (state_q)
			S_ESC: begin
				byte_c  = CH_ESC;
				state_n = S_LBRK;
			end
			S_LBRK: begin
				byte_c  = CH_LBRACKET;
				state_n = S_INTRO;
			end
			S_INTRO: begin
				byte_c  = q_desc.sgr ? CH_LESS : CH_UPPER_M;
				state_n = q_desc.sgr ? S_CODE : S_LCODE;
				dig_n   = q_desc.len_c;
			end
			S_LCODE: begin
				byte_c  = q_desc.b_code;
				state_n = S_LX;
			end
			S_LX: begin
				byte_c  = q_desc.b_x;
				state_n = S_LY;
			end
			S_LY: begin
				byte_c  = q_desc.b_y;
				last_c  = 1'b1;
				state_n = S_ESC;
			end
			S_CODE: begin
				digit  = q_desc.dig_c[dig_q];
				byte_c = CH_ZERO + {4'd0, digit};
				if (dig_q == 2'd0)
					state_n = S_SEMI1;
				else
					dig_n = dig_q - 2'd1;
			end
			S_SEMI1: begin
				byte_c  = CH_SEMI;
				dig_n   = q_desc.len_x;
				state_n = S_XNUM;
			end
			S_XNUM: begin
				digit  = q_desc.dig_x[dig_q];
				byte_c = CH_ZERO + {4'd0, digit};
				if (dig_q == 2'd0)
					state_n = S_SEMI2;
				else
					dig_n = dig_q - 2'd1;
			end
			S_SEMI2: begin
				byte_c  = CH_SEMI;
				dig_n   = q_desc.len_y;
				state_n = S_YNUM;
			end
			S_YNUM: begin
				digit  = q_desc.dig_y[dig_q];
				byte_c = CH_ZERO + {4'd0, digit};
				if (dig_q == 2'd0)
					state_n = S_TERM;
				else
					dig_n = dig_q - 2'd1;
			end
			S_TERM: begin
				byte_c  = q_desc.rel ? CH_LOWER_M : CH_UPPER_M;
				last_c  = 1'b1;
				state_n = S_ESC;
			end
			default: begin
				state_n = S_ESC;
			end
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ESC;
			dig_q   <= 2'd0;
		end else if (emit) begin
			state_q <= state_n;
			dig_q   <= dig_n;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= byte_c;
			last_q <= last_c;
		end
	end

	`TMRE_ASSERT(a_pop_at_end, clk, arst_n,
		q_pop |-> (state_q == S_LY || state_q == S_TERM), "descriptor released mid-report")
	`TMRE_ASSERT(a_mid_has_desc, clk, arst_n,
		(state_q != S_ESC) |-> !q_empty, "report in progress without a descriptor")

endmodule

// ----- hw/rtl/terminal_mouse_report_encoder.sv -----
// ----------------------------------------------------------------------------
// Terminal mouse report encoder - top level
// Encodes mouse events into legacy or SGR terminal report byte streams.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  event     in         push / full           button_code event_kind modifiers
//                                             column row
//  report    out        empty / pop           out_byte last_byte
//  config    in         cfg_we (no wait)      cfg_index cfg_data
//
// The back serializer sends one byte per cycle while the consumer pops; a
// legacy report has six bytes, an SGR report nine to seventeen. The front runs
// no digit steps for legacy or filtered events, four decimal ones per SGR event.
// Reset clears the control state; there is no clearing pass after reset.
// A stalled output holds its byte while the front keeps taking events until
// the two-entry descriptor queue fills.
// ----------------------------------------------------------------------------
module terminal_mouse_report_encoder import tmre_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [6:0]            button_code,
	input  logic [1:0]            event_kind,
	input  logic                  shift_held,
	input  logic                  option_held,
	input  logic                  control_held,
	input  logic [11:0]           column,
	input  logic [11:0]           row,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            out_byte,
	output logic                  last_byte,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [1:0] tracking_mode_q;
	logic       sgr_format_q;
	logic       fq_push, fq_full, bq_pop, bq_empty;
	tmre_desc_t fq_desc, bq_desc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_mode_q <= MODE_RESET;
			sgr_format_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TRACKING_MODE: tracking_mode_q <= cfg_data[1:0];
				REG_SGR_FORMAT:    sgr_format_q    <= cfg_data[0];
				default:           sgr_format_q    <= sgr_format_q;
			endcase
		end
	end

	tmre_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.button_code   (button_code),
		.event_kind    (event_kind),
		.shift_held    (shift_held),
		.option_held   (option_held),
		.control_held  (control_held),
		.column        (column),
		.row           (row),
		.tracking_mode (tracking_mode_q),
		.sgr_format    (sgr_format_q),
		.q_push        (fq_push),
		.q_desc        (fq_desc),
		.q_full        (fq_full)
	);

	tmre_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_desc),
		.full   (fq_full),
		.pop    (bq_pop),
		.rdata  (bq_desc),
		.empty  (bq_empty)
	);

	tmre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (bq_empty),
		.q_desc    (bq_desc),
		.q_pop     (bq_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule
